// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock, disabled in reset
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("%m: check failed");
// plain always-true property on every clock
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("%m: check failed");
`endif

// ===== hdl/qspg_pkg.sv =====
// Types and constants for the four-channel step/dir pulse generator.
// No dependencies.
package qspg_pkg;
    localparam int unsigned SPR_W  = 16;
    localparam int unsigned MICRO_W = 8;
    localparam int unsigned SPEED_W = 16;
    localparam int unsigned CORR_W = 24;
    localparam int unsigned HALF_W = 32;
    // r fits in 25 bits signed positive part: speed*256+corr < 2^25
    localparam int unsigned R_W = 25;
    // D = spr*micro*r < 2^49
    localparam int unsigned D_W = 49;
    // numerator 2*60e6*256 + D fits in 50 bits
    localparam int unsigned NUM_W = 50;
    localparam logic [NUM_W-1:0] US_MIN_Q8_X2 = NUM_W'(64'd30720000000);

    localparam logic [1:0] REG_SPR   = 2'd0;
    localparam logic [1:0] REG_MICRO = 2'd1;
    localparam logic [1:0] REG_INV   = 2'd2;

    localparam logic MODE_TICK   = 1'b0;
    localparam logic MODE_UPDATE = 1'b1;

    // one entry of the motor parameter memory
    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic [CORR_W-1:0]  corr;
        logic               run;
        logic               dir;
    } param_t;

    // request to the divider and its answer
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
    } div_rsp_t;
endpackage

// ===== hdl/quad_step_pulse_generator_top.sv =====
// Top level of the four-channel step/dir pulse generator.
// Depends on qspg_pkg, qspg_divider and assert_macros.svh.
//
//  port group  | dir | contents
//  s_axis      | in  | tuser: mode; tdata: motor, speed_rpm, speed_correction, run, clockwise
//  m_axis      | out | tdata: step levels, dir levels, half_period
//  APB         | in  | steps_per_rev @0, microstep_factor @4, dir_invert_mask @8
//
// A tick reads each motor's counter entry and, for a running motor, writes it
// back in the cycle after the read; then the reported entry is read. An update
// whose parameters change runs the multiply path and the 50-step serial
// divider; an unchanged one skips both, a zero period does not wait for it.
// One item at a time; with a second result held at the output the input stalls.
// Reset is synchronous, active low; no clearing pass (memories reset per entry
// via valid bits).
module quad_step_pulse_generator_top
    import qspg_pkg::*;
#(
    parameter int unsigned MOTORS = 4,
    parameter int unsigned PERIOD_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] mode
    input  logic        s_tuser,
    // [1:0] motor, [17:2] speed_rpm, [41:18] speed_correction,
    // [42] run, [43] clockwise, [47:44] zero
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] step levels, [7:4] dir levels, [39:8] half_period
    output logic [39:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int unsigned MI_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;
    localparam int unsigned PB = PERIOD_BITS;
    localparam logic [NUM_W-1:0] HALF_MAX = NUM_W'((64'd1 << PB) - 64'd1);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PREAD = 7'b0000010,
        ST_PCHK  = 7'b0000100,
        ST_MUL   = 7'b0001000,
        ST_DIV   = 7'b0010000,
        ST_TICK  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    // ---------------- configuration ----------------
    logic [SPR_W-1:0]   spr_reg;
    logic [MICRO_W-1:0] micro_reg;
    logic [3:0]         inv_reg;
    logic               cfg_wr;
    logic [1:0]         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spr_reg   <= SPR_W'(200);
            micro_reg <= MICRO_W'(1);
            inv_reg   <= 4'd6;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_SPR:   spr_reg   <= pwdata[SPR_W-1:0];
                REG_MICRO: micro_reg <= pwdata[MICRO_W-1:0];
                REG_INV:   inv_reg   <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_SPR:   prdata = {16'd0, spr_reg};
            REG_MICRO: prdata = {24'd0, micro_reg};
            REG_INV:   prdata = {28'd0, inv_reg};
            default:   prdata = '0;
        endcase
    end

    // ---------------- memories ----------------
    // parameter memory: last speed/corr/run/dir
    param_t            pmem [MOTORS];
    logic [MOTORS-1:0] pvalid_reg;
    param_t            prd_reg;
    logic              pwe;
    logic [MI_W-1:0]   paddr_m;
    param_t            pwd;

    // counter memory: {half, count}
    logic [2*PB-1:0]   cmem [MOTORS];
    logic [MOTORS-1:0] cvalid_reg;
    logic [2*PB-1:0]   crd_reg;
    logic              crd_vld_reg;
    logic              cre, cwe;
    logic [MI_W-1:0]   craddr, cwaddr;
    logic [2*PB-1:0]   cwd;

    always_ff @(posedge aclk) begin
        if (pwe) pmem[paddr_m] <= pwd;
        prd_reg <= pmem[paddr_m];
        if (cwe) cmem[cwaddr] <= cwd;
        if (cre) begin
            crd_reg     <= cmem[craddr];
            crd_vld_reg <= cvalid_reg[craddr];
        end
    end

    // ---------------- control ----------------
    state_t            st_reg, st_next;
    logic [44:0]       in_reg;
    logic [MOTORS-1:0] step_reg, step_next;
    logic [MOTORS-1:0] dir_reg, dir_next;
    logic [MOTORS-1:0] runm_reg, runm_next;
    logic [MOTORS-1:0] pv_next, cv_next;
    logic [MI_W:0]     idx_reg, idx_next;
    logic [PB-1:0]     rep_half_reg, rep_half_next;
    logic [R_W:0]      r_reg;
    logic [23:0]       sm_reg;
    logic [D_W-1:0]    d_reg;
    logic              zero_reg;
    logic [39:0]       obuf_reg, obuf_next;
    logic              ovalid_reg, ovalid_next;
    logic              opend_reg, opend_next;
    logic [39:0]       opend_data_reg, opend_data_next;
    logic              in_acc;
    div_req_t          dreq;
    div_rsp_t          drsp;

    logic              i_mode, i_run, i_cw;
    logic [1:0]        i_motor;
    logic [SPEED_W-1:0] i_speed;
    logic [CORR_W-1:0] i_corr;
    logic              m_ok;
    logic [MI_W-1:0]   m_idx;
    param_t            cur_p;
    logic              p_changed;
    logic [PB-1:0]     c_half, c_cnt, c_inc;
    logic [MI_W-1:0]   t_idx;
    logic [NUM_W-1:0]  q_half;
    logic [PB-1:0]     new_half;

    assign i_mode  = in_reg[0];
    assign i_motor = in_reg[2:1];
    assign i_speed = in_reg[18:3];
    assign i_corr  = in_reg[42:19];
    assign i_run   = in_reg[43];
    assign i_cw    = in_reg[44];
    assign m_ok    = 32'(i_motor) < 32'(MOTORS);
    assign m_idx   = MI_W'(i_motor);
    assign t_idx   = idx_reg[MI_W-1:0];

    assign cur_p = pvalid_reg[m_idx] ? prd_reg : param_t'('0);
    assign p_changed = (cur_p.speed != i_speed) || (cur_p.corr != i_corr) ||
                       (cur_p.run != i_run);
    assign c_half = crd_vld_reg ? crd_reg[2*PB-1:PB] : '0;
    assign c_cnt  = crd_vld_reg ? crd_reg[PB-1:0] : '0;
    assign c_inc  = c_cnt + 1'b1;
    assign q_half = drsp.quot >> 1;
    assign new_half = zero_reg ? '0 :
                      (q_half > HALF_MAX) ? PB'(HALF_MAX) : q_half[PB-1:0];

    assign s_tready = (st_reg == ST_IDLE) && !opend_reg;
    assign in_acc   = s_tvalid && s_tready;

    function automatic logic [3:0] to_nibble(input logic [MOTORS-1:0] v);
        logic [3:0] r;
        r = '0;
        for (int i = 0; i < MOTORS && i < 4; i++) r[i] = v[i];
        return r;
    endfunction

    always_comb begin
        st_next         = st_reg;
        step_next       = step_reg;
        dir_next        = dir_reg;
        runm_next       = runm_reg;
        pv_next         = pvalid_reg;
        cv_next         = cvalid_reg;
        idx_next        = idx_reg;
        rep_half_next   = rep_half_reg;
        obuf_next       = obuf_reg;
        ovalid_next     = ovalid_reg;
        opend_next      = opend_reg;
        opend_data_next = opend_data_reg;
        pwe = 1'b0; paddr_m = m_idx; pwd = cur_p;
        cre = 1'b0; craddr = t_idx; cwe = 1'b0; cwaddr = t_idx; cwd = '0;
        dreq = '0;

        if (ovalid_reg && m_tready) begin
            ovalid_next = opend_reg;
            obuf_next   = opend_data_reg;
            opend_next  = 1'b0;
        end

        unique case (st_reg)
            ST_IDLE: begin
                if (in_acc) st_next = ST_PREAD;
            end
            ST_PREAD: begin
                // parameter read issued now; counter entry read for the report, or motor 0's entry for a tick
                paddr_m  = m_idx;
                cre      = 1'b1;
                craddr   = m_idx;
                idx_next = '0;
                if (i_mode == MODE_TICK) begin
                    craddr  = '0;
                    st_next = ST_TICK;
                end else begin
                    st_next = ST_PCHK;
                end
            end
            ST_PCHK: begin
                idx_next = (MI_W+1)'(m_idx);
                rep_half_next = c_half;
                if (!m_ok) begin
                    rep_half_next = '0;
                    st_next = ST_OUT;
                end else begin
                    pwe = 1'b1;
                    pwd = cur_p;
                    pv_next[m_idx] = 1'b1;
                    if (i_cw != cur_p.dir) begin
                        pwd.dir = i_cw;
                        dir_next[m_idx] = ~(i_cw ^ inv_reg[m_idx]);
                    end
                    if (p_changed) begin
                        pwd.speed = i_speed;
                        pwd.corr  = i_corr;
                        pwd.run   = i_run;
                        st_next   = ST_MUL;
                    end else begin
                        st_next = ST_OUT;
                    end
                end
            end
            ST_MUL: begin
                // second product stage done in d_reg pipeline; launch divide
                if (idx_reg[MI_W]) begin
                    dreq.start = 1'b1;
                    dreq.num   = US_MIN_Q8_X2 + NUM_W'(d_reg);
                    dreq.den   = NUM_W'({d_reg, 1'b0});
                    st_next    = ST_DIV;
                end else begin
                    idx_next[MI_W] = 1'b1;
                end
            end
            ST_DIV: begin
                if (zero_reg || drsp.done) begin
                    cwe    = 1'b1;
                    cwaddr = m_idx;
                    cwd    = {new_half, PB'(0)};
                    cv_next[m_idx]   = 1'b1;
                    step_next[m_idx] = 1'b0;
                    runm_next[m_idx] = i_run && (new_half != '0);
                    rep_half_next    = new_half;
                    st_next          = ST_OUT;
                end
            end
            ST_TICK: begin
                // read of motor idx came back; write it back if running, read next
                if (runm_reg[t_idx]) begin
                    cwe = 1'b1;
                    cwaddr = t_idx;
                    cv_next[t_idx] = 1'b1;
                    if (c_inc >= c_half) begin
                        cwd = {c_half, PB'(0)};
                        step_next[t_idx] = ~step_reg[t_idx];
                    end else begin
                        cwd = {c_half, c_inc};
                    end
                end
                if (idx_reg == (MI_W+1)'(MOTORS - 1)) begin
                    // fetch reported entry
                    cre = 1'b1;
                    craddr = m_idx;
                    idx_next = (MI_W+1)'(MOTORS);
                end else if (idx_reg == (MI_W+1)'(MOTORS)) begin
                    idx_next = (MI_W+1)'(m_idx);
                    st_next  = ST_OUT;
                end else begin
                    cre = 1'b1;
                    craddr = MI_W'(idx_reg + 1'b1);
                    idx_next = idx_reg + 1'b1;
                end
                if (idx_reg == (MI_W+1)'(MOTORS)) begin
                    cwe = 1'b0;
                    cv_next = cvalid_reg;
                    step_next = step_reg;
                    rep_half_next = m_ok ? c_half : '0;
                end
            end
            ST_OUT: begin
                opend_data_next = {HALF_W'(rep_half_reg), to_nibble(dir_reg),
                                   to_nibble(step_reg)};
                if (!ovalid_next) begin
                    ovalid_next = 1'b1;
                    obuf_next   = opend_data_next;
                end else begin
                    opend_next = 1'b1;
                end
                st_next = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    // multiply path: r and spr*micro registered together, then their product
    logic [23:0] sm_prod;
    logic signed [R_W:0] r_calc;
    assign sm_prod = spr_reg * micro_reg;
    assign r_calc  = $signed({2'b00, i_speed, 8'd0}) + $signed({{2{i_corr[CORR_W-1]}}, i_corr});

    always_ff @(posedge aclk) begin
        r_reg    <= r_calc;
        sm_reg   <= sm_prod;
        zero_reg <= (sm_prod == '0) || r_calc[R_W] || (r_calc == '0);
        d_reg    <= D_W'(sm_reg) * D_W'(r_reg[R_W-1:0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= ST_IDLE;
            step_reg   <= '0;
            dir_reg    <= '1;
            runm_reg   <= '0;
            pvalid_reg <= '0;
            cvalid_reg <= '0;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
            opend_reg  <= 1'b0;
        end else begin
            st_reg     <= st_next;
            step_reg   <= step_next;
            dir_reg    <= dir_next;
            runm_reg   <= runm_next;
            pvalid_reg <= pv_next;
            cvalid_reg <= cv_next;
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
            opend_reg  <= opend_next;
        end
        if (in_acc) in_reg <= {s_tdata[43:0], s_tuser};
        rep_half_reg   <= rep_half_next;
        obuf_reg       <= obuf_next;
        opend_data_reg <= opend_data_next;
    end

    qspg_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = obuf_reg;

`include "assert_macros.svh"
    `ASSERT_CLK(a_stopped_low, aclk, aresetn, (st_reg == ST_IDLE) |-> ((step_reg & ~runm_reg) == '0))
    `ASSERT_CLK(a_pend_needs_valid, aclk, aresetn, opend_reg |-> ovalid_reg)
    `ASSERT_CLK(a_no_accept_busy, aclk, aresetn, (st_reg != ST_IDLE) |-> !s_tready)
endmodule

// ===== hdl/qspg_divider.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on qspg_pkg and assert_macros.svh.
module qspg_divider
    import qspg_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);
    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [NUM_W:0]   rem_reg, rem_next;
    logic [NUM_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [NUM_W:0]   trial;

    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (req.start) begin
            quot_next = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            trial = {rem_reg[NUM_W-1:0], quot_reg[NUM_W-1]};
            if (trial >= {1'b0, den_reg}) begin
                rem_next  = trial - {1'b0, den_reg};
                quot_next = {quot_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next  = trial;
                quot_next = {quot_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

`include "assert_macros.svh"
    `ASSERT_CLK(a_done_after_busy, aclk, aresetn, done_reg |-> $past(busy_reg))
    `ASSERT_CLK(a_no_done_while_busy, aclk, aresetn, done_reg |-> !busy_reg)
endmodule

// ===== test/quad_step_pulse_generator_top_tb.sv =====
// Testbench for the four-channel step/dir pulse generator top level.
// Streams ticks and motor updates, predicts every result, and checks it.
// Depends on qspg_pkg and quad_step_pulse_generator_top.
`timescale 1ns / 1ps

module quad_step_pulse_generator_top_tb
    import qspg_pkg::*;
();

    localparam int LIMIT = 2000000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic        s_tuser = 1'b0;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    quad_step_pulse_generator_top dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    typedef struct packed {
        logic        cw;
        logic        run;
        logic [23:0] corr;
        logic [15:0] speed;
        logic [1:0]  motor;
        logic        mode;
    } cmd_t;

    typedef struct packed {
        logic [31:0] half;
        logic [3:0]  dir;
        logic [3:0]  step;
    } pins_t;

    // predictor state
    logic [15:0] spr;
    logic [7:0]  micro;
    logic [3:0]  inv_mask;
    logic [15:0] p_speed [4];
    logic [23:0] p_corr [4];
    logic        p_run [4];
    logic        p_cw [4];
    logic [31:0] p_half [4];
    logic [31:0] p_count [4];
    logic [3:0]  step_lv;
    logic [3:0]  dir_lv;
    logic        p_going [4];

    cmd_t  pending_cmds[$];
    pins_t expected_pins[$];
    int    errors = 0;
    int    cycles = 0;

    function automatic logic [31:0] half_period_of(logic [15:0] speed, logic [23:0] corr);
        longint r;
        longint unsigned d, p, h;
        r = longint'(speed) * 256 + longint'($signed(corr));
        if (spr == 0 || micro == 0 || r <= 0) return 32'd0;
        d = longint'(spr) * longint'(micro) * r;
        p = (2 * 64'd15360000000 + d) / (2 * d);
        h = p / 2;
        if (h > 64'hFFFF_FFFF) h = 64'hFFFF_FFFF;
        return h[31:0];
    endfunction

    function automatic pins_t advance_motors(cmd_t c);
        pins_t o;
        int m;
        m = c.motor;
        if (c.mode == MODE_UPDATE) begin
            if (c.speed != p_speed[m] || c.corr != p_corr[m] || c.run != p_run[m]) begin
                p_speed[m] = c.speed;
                p_corr[m] = c.corr;
                p_run[m] = c.run;
                p_half[m] = half_period_of(c.speed, c.corr);
                p_count[m] = 0;
                step_lv[m] = 1'b0;
                p_going[m] = c.run && p_half[m] != 0;
            end
            if (c.cw != p_cw[m]) begin
                p_cw[m] = c.cw;
                dir_lv[m] = ~(c.cw ^ inv_mask[m]);
            end
        end else begin
            for (int i = 0; i < 4; i++) begin
                if (p_going[i]) begin
                    p_count[i]++;
                    if (p_count[i] >= p_half[i]) begin
                        p_count[i] = 0;
                        step_lv[i] = ~step_lv[i];
                    end
                end
            end
        end
        o.step = step_lv;
        o.dir = dir_lv;
        o.half = p_half[m];
        return o;
    endfunction

    function automatic int rand_gap();
        return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 4);
    endfunction

    // driver
    int s_gap = 0;
    always @(posedge aclk) begin : drv
        cmd_t nxt;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                expected_pins.push_back(advance_motors(cmd_t'({s_tdata[43:0], s_tuser})));
            if (!s_tvalid || s_tready) begin
                if (s_gap > 0) begin
                    s_gap <= s_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    nxt = pending_cmds.pop_front();
                    s_tuser <= nxt.mode;
                    s_tdata <= {4'b0, nxt[44:1]};
                    s_tvalid <= 1'b1;
                    s_gap <= ($urandom_range(0, 3) == 0) ? rand_gap() : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int m_hold = 0;
    always @(posedge aclk) begin
        pins_t got, want;
        cycles <= cycles + 1;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = pins_t'(m_tdata);
                if (expected_pins.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    errors++;
                end else begin
                    want = expected_pins.pop_front();
                    if (got.step !== want.step) begin
                        $display("%0t: step levels expected %h actual %h", $time, want.step,
                                 got.step);
                        errors++;
                    end
                    if (got.dir !== want.dir) begin
                        $display("%0t: dir levels expected %h actual %h", $time, want.dir,
                                 got.dir);
                        errors++;
                    end
                    if (got.half !== want.half) begin
                        $display("%0t: half_period expected %0d actual %0d", $time,
                                 want.half, got.half);
                        errors++;
                    end
                end
            end
            if (m_hold > 0) begin
                m_hold <= m_hold - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 4) == 0) m_hold <= rand_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles >= LIMIT) begin
            $display("quad_step_pulse_generator_top test failed");
            $finish;
        end
    end

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_SPR:   spr = val[15:0];
            REG_MICRO: micro = val[7:0];
            default:   inv_mask = val[3:0];
        endcase
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() > 0 || s_tvalid || expected_pins.size() > 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    function automatic cmd_t make_update(int m, int speed, int corr, bit run, bit cw);
        cmd_t c;
        c.mode = MODE_UPDATE;
        c.motor = 2'(m);
        c.speed = 16'(speed);
        c.corr = 24'(corr);
        c.run = run;
        c.cw = cw;
        return c;
    endfunction

    function automatic cmd_t make_tick();
        cmd_t c;
        c = cmd_t'(45'({$urandom(), $urandom()}));
        c.mode = MODE_TICK;
        return c;
    endfunction

    // speeds mostly drawn from a high range (lower bound set by spr*micro); one update in ten is fully random
    function automatic cmd_t rand_update();
        int sp;
        if ($urandom_range(0, 9) == 0)
            return make_update($urandom_range(0, 3), $urandom(), $urandom(),
                               $urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0);
        sp = (spr * micro > 1000) ? $urandom_range(1000, 65535) : $urandom_range(3000, 65535);
        return make_update($urandom_range(0, 3), sp, $urandom_range(0, 4095) - 2048,
                           $urandom_range(0, 5) != 0, $urandom_range(0, 1) != 0);
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
            pending_cmds.push_back($urandom_range(0, 5) == 0 ? rand_update() : make_tick());
        wait_idle();
    endtask

    initial begin
        spr = 16'd200;
        micro = 8'd1;
        inv_mask = 4'd6;
        step_lv = '0;
        dir_lv = 4'hF;
        for (int i = 0; i < 4; i++) begin
            p_speed[i] = '0; p_corr[i] = '0; p_run[i] = 0; p_cw[i] = 0;
            p_half[i] = '0; p_count[i] = '0; p_going[i] = 0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, stopped motors, negative r, ticks
        pending_cmds.push_back(make_update(0, 65535, 24'h7FFFFF, 1, 1));
        pending_cmds.push_back(make_update(1, 0, 24'h800000, 1, 0));
        pending_cmds.push_back(make_update(2, 1, 24'hFFFF01, 1, 1));
        pending_cmds.push_back(make_update(3, 0, 1, 1, 1));
        pending_cmds.push_back(make_tick());
        pending_cmds.push_back(make_update(1, 30000, 0, 1, 1));
        pending_cmds.push_back(make_update(2, 60000, 24'hFFFF00, 0, 0));
        pending_cmds.push_back(make_update(2, 60000, 24'hFFFF00, 1, 0));
        pending_cmds.push_back(make_update(0, 60000, 0, 1, 0));
        for (int i = 0; i < 8; i++) pending_cmds.push_back(make_tick());
        pending_cmds.push_back(make_update(3, 1, 0, 1, 0));
        pending_cmds.push_back(make_update(3, 1, 0, 1, 0));
        wait_idle();

        apb_write(REG_SPR, 32'd0);
        random_phase(80);
        apb_write(REG_SPR, 32'd65535);
        apb_write(REG_MICRO, 32'd255);
        apb_write(REG_INV, 32'd15);
        pending_cmds.push_back(make_update(0, 1, 1, 1, 0));
        random_phase(250);
        apb_write(REG_MICRO, 32'd0);
        apb_write(REG_INV, 32'd0);
        random_phase(80);
        apb_write(REG_SPR, 32'd1);
        apb_write(REG_MICRO, 32'd1);
        pending_cmds.push_back(make_update(1, 0, 1, 1, 1));
        random_phase(150);
        apb_write(REG_SPR, 32'd200);
        apb_write(REG_MICRO, 32'd16);
        apb_write(REG_INV, 32'd9);
        random_phase(600);

        if (errors == 0) begin
            $display("quad_step_pulse_generator_top test passed");
        end else begin
            $display("quad_step_pulse_generator_top test failed");
        end
        $finish;
    end
endmodule
